>>> rtl/core/nrp_pkg.sv
// shared constants, types and helper functions of the rmc position parser
package nrp_pkg;

  localparam int CAPTURE_DEPTH_DEF = 128;
  localparam int STATUS_OFFSET_DEF = 18;
  localparam int FRAC_DIGITS_DEF = 4;

  localparam logic [7:0] CAPTURE_LIMIT_RESET = 8'd90;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END = 1'b1;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_NOT_RMC = 3'd2;
  localparam logic [2:0] ST_NO_FIX = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_W = 8'h57;

  localparam logic [16:0] WHOLE_MAX = 17'd131071;
  localparam logic [34:0] LAT_MAX = 35'd900000000;
  localparam logic [34:0] LON_MAX = 35'd1800000000;

  // which field a magnitude computation belongs to
  typedef struct packed {
    logic valid;
    logic is_lon;
  } mag_ctl_t;

  // capture-end item travelling alongside the magnitude pipeline
  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic       lat_neg;
    logic       lon_neg;
  } tok_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    case (n)
      0: r = 64'd1;
      1: r = 64'd10;
      2: r = 64'd100;
      3: r = 64'd1000;
      4: r = 64'd10000;
      5: r = 64'd100000;
      6: r = 64'd1000000;
      7: r = 64'd10000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

  // characters of the expected sentence header
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h24;
      3'd1: r = 8'h47;
      3'd2: r = 8'h4E;
      3'd3: r = 8'h52;
      3'd4: r = 8'h4D;
      3'd5: r = 8'h43;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/nmea_rmc_position_parser.sv
// rmc sentence position parser: byte filter, field parser and result output
//
//  channel | signals                                          | accepted when
//  in      | in_valid in_ready operation rx_byte              | in_valid && in_ready
//  out     | out_valid out_ready status latitude longitude    | out_valid && out_ready
//  cfg     | cfg_we cfg_wdata                                 | cfg_we
//
// one input item per cycle while in_ready is high; a byte updates the parser state in its accept cycle
// a capture-end item passes the tok shift register, then out_valid rises from the output register,
// after the magnitude pipeline (reciprocal multiplies for /100 and /6) has drained behind it
// rst is synchronous and clears all control state, capture_limit returns to 90
// in_ready drops only while a result sits at the pipeline end and the output
// register is still full
module nmea_rmc_position_parser
  import nrp_pkg::*;
#(
  parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
  parameter int STATUS_OFFSET = STATUS_OFFSET_DEF,
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [30:0] latitude,
  output logic signed [31:0] longitude,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  localparam int KW = $clog2(CAPTURE_DEPTH + 1);
  localparam int FW = $clog2(pow10(FRAC_DIGITS));
  localparam int FCW = $clog2(FRAC_DIGITS + 1);
  localparam logic [7:0] STATUS_POS = 8'(STATUS_OFFSET);
  localparam logic [FCW-1:0] FC_MAX = FCW'(FRAC_DIGITS);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_FIELD_START,
    PH_WHOLE,
    PH_FRAC,
    PH_SKIP
  } phase_t;

  logic [7:0]     capture_limit;
  logic [KW-1:0]  kept_count, kept_count_next;
  logic [7:0]     sentence_pos, sentence_pos_next;
  phase_t         parse_phase, parse_phase_next;
  logic [3:0]     comma_count, comma_count_next;
  logic           header_match, header_match_next;
  logic           fix_seen, fix_seen_next;
  logic [16:0]    whole_acc, whole_acc_next;
  logic [FW-1:0]  frac_acc, frac_acc_next;
  logic [FCW-1:0] frac_count, frac_count_next;
  logic           lat_neg, lat_neg_next;
  logic           lon_neg, lon_neg_next;

  tok_t           tok_in;
  tok_t           tok [5];
  mag_ctl_t       mag_ctl;
  logic [29:0]    lat_mag;
  logic [30:0]    lon_mag;

  logic           adv;
  logic           in_acc;
  logic [KW-1:0]  limit;
  logic           is_digit;
  logic [3:0]     digit;
  logic [20:0]    whole_mul;
  phase_t         eff_phase;
  logic [FW-1:0]  frac_weight;
  logic [2:0]     end_status;
  logic [30:0]    lat_res;
  logic [31:0]    lon_res;

  assign adv = !(tok[4].valid && out_valid && !out_ready);
  assign in_ready = adv;
  assign in_acc = in_valid && adv;

  always_comb begin
    limit = (9'(capture_limit) > 9'(CAPTURE_DEPTH)) ? KW'(CAPTURE_DEPTH)
                                                     : KW'(capture_limit);
    is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    digit = 4'(rx_byte - CH_ZERO);
    whole_mul = 21'(whole_acc) * 21'(10) + 21'(digit);
    eff_phase = (parse_phase == PH_WAIT || parse_phase == PH_FIELD_START) ? PH_WHOLE
                                                                          : parse_phase;
    frac_weight = FW'(pow10(FRAC_DIGITS - 1 - int'(frac_count)));

    if (kept_count == '0) begin
      end_status = ST_EMPTY;
    end else if (parse_phase == PH_WAIT || sentence_pos < 8'd6 || !header_match) begin
      end_status = ST_NOT_RMC;
    end else if (sentence_pos <= STATUS_POS) begin
      end_status = ST_TRUNCATED;
    end else if (!fix_seen) begin
      end_status = ST_NO_FIX;
    end else if (comma_count < 4'd6) begin
      end_status = ST_TRUNCATED;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    kept_count_next = kept_count;
    sentence_pos_next = sentence_pos;
    parse_phase_next = parse_phase;
    comma_count_next = comma_count;
    header_match_next = header_match;
    fix_seen_next = fix_seen;
    whole_acc_next = whole_acc;
    frac_acc_next = frac_acc;
    frac_count_next = frac_count;
    lat_neg_next = lat_neg;
    lon_neg_next = lon_neg;
    tok_in = '0;
    mag_ctl = '0;

    if (in_acc && operation == OP_END) begin
      tok_in.valid = 1'b1;
      tok_in.status = end_status;
      tok_in.lat_neg = lat_neg;
      tok_in.lon_neg = lon_neg;
      kept_count_next = '0;
      sentence_pos_next = '0;
      parse_phase_next = PH_WAIT;
      comma_count_next = '0;
      header_match_next = 1'b1;
      fix_seen_next = 1'b0;
      whole_acc_next = '0;
      frac_acc_next = '0;
      frac_count_next = '0;
      lat_neg_next = 1'b0;
      lon_neg_next = 1'b0;
    end else if (in_acc && rx_byte != CH_LF && rx_byte != CH_CR && rx_byte != CH_NUL
                 && kept_count < limit) begin
      kept_count_next = kept_count + KW'(1);
      if (parse_phase != PH_WAIT || rx_byte == CH_DOLLAR) begin
        if (sentence_pos < 8'd6 && rx_byte != header_char(sentence_pos[2:0])) begin
          header_match_next = 1'b0;
        end
        if (sentence_pos == STATUS_POS) begin
          fix_seen_next = (rx_byte == CH_A);
        end
        if (sentence_pos != 8'd255) begin
          sentence_pos_next = sentence_pos + 8'd1;
        end
        // hemisphere letter is the first byte of the field after a coordinate
        if (parse_phase == PH_FIELD_START && (rx_byte == CH_S || rx_byte == CH_W)) begin
          if (comma_count == 4'd4) begin
            lat_neg_next = 1'b1;
          end else if (comma_count == 4'd6) begin
            lon_neg_next = 1'b1;
          end
        end
        parse_phase_next = eff_phase;

        if (rx_byte == CH_COMMA) begin
          mag_ctl.valid = (comma_count == 4'd3) || (comma_count == 4'd5);
          mag_ctl.is_lon = (comma_count == 4'd5);
          if (comma_count != 4'd15) begin
            comma_count_next = comma_count + 4'd1;
          end
          whole_acc_next = '0;
          frac_acc_next = '0;
          frac_count_next = '0;
          parse_phase_next = PH_FIELD_START;
        end else if (eff_phase == PH_WHOLE) begin
          if (is_digit) begin
            whole_acc_next = (whole_mul > 21'(WHOLE_MAX)) ? WHOLE_MAX : whole_mul[16:0];
          end else begin
            parse_phase_next = (rx_byte == CH_DOT) ? PH_FRAC : PH_SKIP;
          end
        end else if (eff_phase == PH_FRAC) begin
          if (is_digit) begin
            // digits land at their place value, missing ones stay zero
            if (frac_count < FC_MAX) begin
              frac_acc_next = frac_acc + FW'(digit) * frac_weight;
              frac_count_next = frac_count + FCW'(1);
            end
          end else begin
            parse_phase_next = PH_SKIP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_limit <= CAPTURE_LIMIT_RESET;
    end else if (cfg_we) begin
      capture_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      sentence_pos <= '0;
      parse_phase <= PH_WAIT;
      comma_count <= '0;
      header_match <= 1'b1;
      fix_seen <= 1'b0;
      whole_acc <= '0;
      frac_acc <= '0;
      frac_count <= '0;
      lat_neg <= 1'b0;
      lon_neg <= 1'b0;
    end else begin
      kept_count <= kept_count_next;
      sentence_pos <= sentence_pos_next;
      parse_phase <= parse_phase_next;
      comma_count <= comma_count_next;
      header_match <= header_match_next;
      fix_seen <= fix_seen_next;
      whole_acc <= whole_acc_next;
      frac_acc <= frac_acc_next;
      frac_count <= frac_count_next;
      lat_neg <= lat_neg_next;
      lon_neg <= lon_neg_next;
    end
  end

  nrp_magnitude #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .FW(FW)
  ) u_magnitude (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (mag_ctl),
    .whole_in(whole_acc),
    .frac_in (frac_acc),
    .lat_mag (lat_mag),
    .lon_mag (lon_mag)
  );

  // end item trails any magnitude launched before it by the same distance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        tok[i] <= '0;
      end
    end else if (adv) begin
      tok[0] <= tok_in;
      for (int i = 1; i < 5; i++) begin
        tok[i] <= tok[i-1];
      end
    end
  end

  always_comb begin
    lat_res = '0;
    lon_res = '0;
    if (tok[4].status == ST_OK) begin
      lat_res = tok[4].lat_neg ? -{1'b0, lat_mag} : {1'b0, lat_mag};
      lon_res = tok[4].lon_neg ? -{1'b0, lon_mag} : {1'b0, lon_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && tok[4].valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok[4].valid) begin
      status <= tok[4].status;
      latitude <= lat_res;
      longitude <= lon_res;
    end
  end

endmodule

>>> rtl/core/nrp_magnitude.sv
// pipelined ddmm.mmmm to 1e-7 degree magnitude conversion, holds latest lat and lon
module nrp_magnitude
  import nrp_pkg::*;
#(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int FW = $clog2(pow10(FRAC_DIGITS))
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  mag_ctl_t      ctl_in,
  input  logic [16:0]   whole_in,
  input  logic [FW-1:0] frac_in,
  output logic [29:0]   lat_mag,
  output logic [30:0]   lon_mag
);

  localparam logic [26:0] FSCALE = 27'(pow10(6 - FRAC_DIGITS));

  mag_ctl_t    ctl2, ctl3, ctl4, ctl5;
  logic [16:0] whole2, whole3;
  logic [FW-1:0] frac2, frac3;
  logic [10:0] deg3, deg4;
  logic [26:0] z4, z5;
  logic [33:0] dpart5;

  logic [34:0] deg_prod;
  logic [16:0] mins_full;
  logic [6:0]  mins;
  logic [26:0] z;
  logic [33:0] dpart;
  logic [57:0] q_prod;
  logic [23:0] q;
  logic [34:0] sum;

  always_comb begin
    // whole / 100 by reciprocal, exact below 2^17
    deg_prod = 35'(whole2) * 35'(167773);
    mins_full = whole3 - 17'(deg3) * 17'(100);
    mins = mins_full[6:0];
    z = 27'(mins) * 27'(1000000) + 27'(frac3) * FSCALE;
    dpart = 34'(deg4) * 34'(10000000);
    // z / 6 as (z >> 1) / 3 by reciprocal
    q_prod = 58'(z5[26:1]) * 58'(32'hAAAAAAAB);
    q = q_prod[56:33];
    sum = {1'b0, dpart5} + 35'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
    end else if (adv) begin
      ctl2 <= ctl_in;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      whole2 <= whole_in;
      frac2 <= frac_in;
      whole3 <= whole2;
      frac3 <= frac2;
      deg3 <= deg_prod[34:24];
      deg4 <= deg3;
      z4 <= z;
      z5 <= z4;
      dpart5 <= dpart;
      if (ctl5.valid && !ctl5.is_lon) begin
        lat_mag <= (sum > LAT_MAX) ? LAT_MAX[29:0] : sum[29:0];
      end
      if (ctl5.valid && ctl5.is_lon) begin
        lon_mag <= (sum > LON_MAX) ? LON_MAX[30:0] : sum[30:0];
      end
    end
  end

endmodule
